### hw/rtl/hierarchy_max_parent_aggregate_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the class-hierarchy score layer
// Shorthands for clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef HIERARCHY_MAX_PARENT_AGGREGATE_TOP_ASSERT_SVH
`define HIERARCHY_MAX_PARENT_AGGREGATE_TOP_ASSERT_SVH

// Same-cycle implication.
`define HMPA_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HMPA_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hmpa_pkg.sv
// ----------------------------------------------------------------------------
// hmpa_pkg
// Field widths, command, status and result-kind codes of the score layer.
// ----------------------------------------------------------------------------
package hmpa_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 2;
  localparam int CFG_W  = 11;
  localparam int STAT_W = 2;
  localparam int SLOTS  = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_SCORE   = 3'd0,
    CMD_LOAD_PARENTS = 3'd1,
    CMD_FORWARD      = 3'd2,
    CMD_BACKWARD     = 3'd3,
    CMD_READ_GRAD    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_CLASS  = 2'd1,
    STAT_BAD_PARENT = 2'd2
  } stat_t;

  typedef enum logic {
    KIND_FORWARD = 1'b0,
    KIND_GRAD    = 1'b1
  } kind_t;

endpackage

### hw/rtl/hmpa_chan_if.sv
// ----------------------------------------------------------------------------
// hmpa channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface hmpa_in_if;
  import hmpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        class_index;
  logic signed [VAL_W-1:0] value;
  logic [CNT_W-1:0]        parent_count;
  logic [IDX_W-1:0]        parent_a;
  logic [IDX_W-1:0]        parent_b;
  logic [IDX_W-1:0]        parent_c;

  modport source (output valid, command, class_index, value, parent_count,
                  parent_a, parent_b, parent_c, input ready);
  modport sink (input valid, command, class_index, value, parent_count,
                parent_a, parent_b, parent_c, output ready);
endinterface

interface hmpa_out_if;
  import hmpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    result_kind;
  logic signed [VAL_W-1:0] result_value;
  logic                    has_parent;
  logic [IDX_W-1:0]        chosen_parent;
  logic [STAT_W-1:0]       status;

  modport source (output valid, result_kind, result_value, has_parent,
                  chosen_parent, status, input ready);
  modport sink (input valid, result_kind, result_value, has_parent,
                chosen_parent, status, output ready);
endinterface

interface hmpa_cfg_if;
  import hmpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/hierarchy_max_parent_aggregate_top.sv
// ----------------------------------------------------------------------------
// hierarchy_max_parent_aggregate_top
// Class-hierarchy score layer: max-parent forward, gradient accumulation.
// ----------------------------------------------------------------------------
// One request is processed at a time by a small sequencer around one shared
// saturating adder and one signed comparator; ready is high only when the
// sequencer is idle. Load score and load parents write their memory, and
// read-and-clear emits the gradient of a class and zeroes it. Backward adds
// the value to the class gradient and then, when a parent is recorded, to
// that parent's gradient. Forward passes the score through when no parent is
// usable; otherwise it fetches the parent scores one after another through
// the single read port of the score memory and adds the best. A result
// waits in an output register, so the next request is taken while it is
// unread; a result-producing step stalls only when the previous result still
// waits. After reset a clearing pass over every class entry zeroes the parent,
// chosen-parent and gradient memories before the first request is accepted;
// configuration writes are taken at any time.
module hierarchy_max_parent_aggregate_top #(
  parameter int NUM_CLASSES = 1024,
  parameter int MAX_PARENTS = 3,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  hmpa_cfg_if.sink          cfg_chan,
  hmpa_in_if.sink           in_chan,
  hmpa_out_if.source        out_chan
);
  import hmpa_pkg::*;

  `include "hierarchy_max_parent_aggregate_top_assert.svh"

  localparam int AW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW  = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
  localparam int NCW = $clog2(NUM_CLASSES + 1);
  localparam int LW  = (NCW > CFG_W) ? NCW : CFG_W;

  localparam logic [CNT_W-1:0]      MPC    = CNT_W'(MAX_PARENTS);
  localparam logic signed [VAL_W:0] SAT_HI = (33'sd1 <<< (SW - 1)) - 33'sd1;
  localparam logic signed [VAL_W:0] SAT_LO = -SAT_HI - 33'sd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_F_CHECK, ST_F_READ, ST_F_CMP, ST_F_SUM,
    ST_B_UPD, ST_B_PREAD, ST_B_PUPD, ST_R_EMIT
  } st_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [SLOTS-1:0][IDX_W-1:0] slot;
  } pm_entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } cm_entry_t;

  function automatic logic signed [VAL_W:0] sx(input logic [SW-1:0] x);
    logic signed [VAL_W:0] r;
    r = {{(VAL_W + 1 - SW){x[SW-1]}}, x};
    return r;
  endfunction

  function automatic logic [SW-1:0] sat_sw(input logic signed [VAL_W:0] v);
    logic [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] i,
                                    input logic [LW-1:0] lim_v);
    return LW'(i) < lim_v;
  endfunction

  // Memories
  logic [SW-1:0] sm_mem [NUM_CLASSES];
  pm_entry_t     pm_mem [NUM_CLASSES];
  cm_entry_t     cm_mem [NUM_CLASSES];
  logic [SW-1:0] gm_mem [NUM_CLASSES];

  logic          sm_we, sm_re, pm_we, pm_re, cm_we, cm_re, gm_we, gm_re;
  logic [AW-1:0] sm_waddr, sm_raddr, pm_waddr, pm_raddr;
  logic [AW-1:0] cm_waddr, cm_raddr, gm_waddr, gm_raddr;
  logic [SW-1:0] sm_wdata, gm_wdata;
  pm_entry_t     pm_wdata;
  cm_entry_t     cm_wdata;
  logic [SW-1:0] sm_rd_r, gm_rd_r;
  pm_entry_t     pm_rd_r;
  cm_entry_t     cm_rd_r;

  // Control and request registers
  st_t                         state_r, state_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]            num_classes_r, num_classes_nxt;
  logic [CMD_W-1:0]            cmd_r, cmd_nxt;
  logic [IDX_W-1:0]            ci_r, ci_nxt;
  logic signed [VAL_W-1:0]     val_r, val_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SLOTS-1:0][IDX_W-1:0] slot_r, slot_nxt;
  logic                        ok_r, ok_nxt;
  logic [SW-1:0]               own_r, own_nxt;
  logic [CNT_W-1:0]            k_r, k_nxt;
  logic [CNT_W-1:0]            n_r, n_nxt;
  logic [SW-1:0]               best_val_r, best_val_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_has_parent_r, out_has_parent_nxt;
  logic [IDX_W-1:0]  out_chosen_r, out_chosen_nxt;
  stat_t             out_status_r, out_status_nxt;

  logic [LW-1:0]         lim;
  logic                  out_free;
  logic signed [VAL_W:0] add_a, add_b, add_sum;
  logic [SW-1:0]         add_sat;
  logic signed [VAL_W:0] sm_rd_x, gm_rd_x, add_sat_x, val_x;
  logic [CNT_W-1:0]      cnt_cap, n_rd;
  logic                  slot_bad, list_bad;
  logic [IDX_W-1:0]      cur_parent;

  assign lim = (LW'(num_classes_r) < LW'(NUM_CLASSES)) ?
               LW'(num_classes_r) : LW'(NUM_CLASSES);
  assign out_free = !out_valid_r || out_chan.ready;

  assign val_x     = {val_r[VAL_W-1], val_r};
  assign sm_rd_x   = sx(sm_rd_r);
  assign gm_rd_x   = sx(gm_rd_r);
  assign add_sat_x = sx(add_sat);

  // Shared saturating adder: forward total or gradient update.
  assign add_a   = (state_r == ST_F_SUM) ? sx(own_r) : gm_rd_x;
  assign add_b   = (state_r == ST_F_SUM) ? sx(best_val_r) : val_x;
  assign add_sum = add_a + add_b;
  assign add_sat = sat_sw(add_sum);

  assign cnt_cap    = (cnt_r > MPC) ? MPC : cnt_r;
  assign n_rd       = (pm_rd_r.count > MPC) ? MPC : pm_rd_r.count;
  assign cur_parent = pm_rd_r.slot[k_r];

  always_comb begin
    slot_bad = 1'b0;
    list_bad = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      if (CNT_W'(k) < cnt_cap && !in_range(slot_r[k], lim)) begin
        slot_bad = 1'b1;
      end
      if (CNT_W'(k) < n_rd && !in_range(pm_rd_r.slot[k], lim)) begin
        list_bad = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    num_classes_nxt = num_classes_r;
    cmd_nxt         = cmd_r;
    ci_nxt          = ci_r;
    val_nxt         = val_r;
    cnt_nxt         = cnt_r;
    slot_nxt        = slot_r;
    ok_nxt          = ok_r;
    own_nxt         = own_r;
    k_nxt           = k_r;
    n_nxt           = n_r;
    best_val_nxt    = best_val_r;
    best_idx_nxt    = best_idx_r;

    out_valid_nxt      = out_valid_r && !out_chan.ready;
    out_kind_nxt       = out_kind_r;
    out_value_nxt      = out_value_r;
    out_has_parent_nxt = out_has_parent_r;
    out_chosen_nxt     = out_chosen_r;
    out_status_nxt     = out_status_r;

    sm_we = 1'b0; sm_waddr = AW'(ci_r); sm_wdata = sat_sw(val_x);
    sm_re = 1'b0; sm_raddr = AW'(ci_r);
    pm_we = 1'b0; pm_waddr = AW'(ci_r); pm_re = 1'b0; pm_raddr = AW'(ci_r);
    pm_wdata.count = cnt_cap;
    for (int k = 0; k < SLOTS; k++) begin
      pm_wdata.slot[k] = (CNT_W'(k) < cnt_cap) ? slot_r[k] : '0;
    end
    cm_we = 1'b0; cm_waddr = AW'(ci_r); cm_re = 1'b0; cm_raddr = AW'(ci_r);
    cm_wdata = '0;
    gm_we = 1'b0; gm_waddr = AW'(ci_r); gm_re = 1'b0; gm_raddr = AW'(ci_r);
    gm_wdata = add_sat;

    if (cfg_chan.valid) begin
      num_classes_nxt = cfg_chan.data;
    end

    unique case (state_r)
      ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_addr_r;
        pm_wdata = '0;
        cm_we    = 1'b1;
        cm_waddr = clr_addr_r;
        gm_we    = 1'b1;
        gm_waddr = clr_addr_r;
        gm_wdata = '0;
        if (clr_addr_r == AW'(NUM_CLASSES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt     = in_chan.command;
          ci_nxt      = in_chan.class_index;
          val_nxt     = in_chan.value;
          cnt_nxt     = in_chan.parent_count;
          slot_nxt[0] = in_chan.parent_a;
          slot_nxt[1] = in_chan.parent_b;
          slot_nxt[2] = in_chan.parent_c;
          ok_nxt      = in_range(in_chan.class_index, lim);
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_t'(cmd_r))
          CMD_LOAD_SCORE: begin
            sm_we     = ok_r;
            state_nxt = ST_IDLE;
          end
          CMD_LOAD_PARENTS: begin
            pm_we     = ok_r && !slot_bad;
            state_nxt = ST_IDLE;
          end
          CMD_FORWARD: begin
            if (ok_r) begin
              sm_re     = 1'b1;
              pm_re     = 1'b1;
              state_nxt = ST_F_CHECK;
            end else if (out_free) begin
              out_valid_nxt      = 1'b1;
              out_kind_nxt       = KIND_FORWARD;
              out_value_nxt      = '0;
              out_has_parent_nxt = 1'b0;
              out_chosen_nxt     = '0;
              out_status_nxt     = STAT_BAD_CLASS;
              state_nxt          = ST_IDLE;
            end
          end
          CMD_BACKWARD: begin
            if (ok_r) begin
              gm_re     = 1'b1;
              cm_re     = 1'b1;
              state_nxt = ST_B_UPD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_READ_GRAD: begin
            if (ok_r) begin
              gm_re     = 1'b1;
              state_nxt = ST_R_EMIT;
            end else if (out_free) begin
              out_valid_nxt      = 1'b1;
              out_kind_nxt       = KIND_GRAD;
              out_value_nxt      = '0;
              out_has_parent_nxt = 1'b0;
              out_chosen_nxt     = '0;
              out_status_nxt     = STAT_BAD_CLASS;
              state_nxt          = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_F_CHECK: begin
        own_nxt = sm_rd_r;
        k_nxt   = '0;
        n_nxt   = n_rd;
        if (list_bad || n_rd == '0) begin
          // No usable parent: the score passes through and none is recorded.
          if (out_free) begin
            cm_we              = 1'b1;
            out_valid_nxt      = 1'b1;
            out_kind_nxt       = KIND_FORWARD;
            out_value_nxt      = sm_rd_x[VAL_W-1:0];
            out_has_parent_nxt = 1'b0;
            out_chosen_nxt     = '0;
            out_status_nxt     = list_bad ? STAT_BAD_PARENT : STAT_OK;
            state_nxt          = ST_IDLE;
          end
        end else begin
          state_nxt = ST_F_READ;
        end
      end
      ST_F_READ: begin
        sm_re     = 1'b1;
        sm_raddr  = AW'(cur_parent);
        state_nxt = ST_F_CMP;
      end
      ST_F_CMP: begin
        // Strictly greater only, so the earliest slot keeps a tie.
        if (k_r == '0 || $signed(sm_rd_r) > $signed(best_val_r)) begin
          best_val_nxt = sm_rd_r;
          best_idx_nxt = cur_parent;
        end
        if (({1'b0, k_r} + 3'd1) < {1'b0, n_r}) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_F_READ;
        end else begin
          state_nxt = ST_F_SUM;
        end
      end
      ST_F_SUM: begin
        if (out_free) begin
          cm_we              = 1'b1;
          cm_wdata.valid     = 1'b1;
          cm_wdata.idx       = best_idx_r;
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = KIND_FORWARD;
          out_value_nxt      = add_sat_x[VAL_W-1:0];
          out_has_parent_nxt = 1'b1;
          out_chosen_nxt     = best_idx_r;
          out_status_nxt     = STAT_OK;
          state_nxt          = ST_IDLE;
        end
      end
      ST_B_UPD: begin
        gm_we = 1'b1;
        if (cm_rd_r.valid && in_range(cm_rd_r.idx, lim)) begin
          state_nxt = ST_B_PREAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_B_PREAD: begin
        // Read after the class update so a self-parent sees the new value.
        gm_re     = 1'b1;
        gm_raddr  = AW'(cm_rd_r.idx);
        state_nxt = ST_B_PUPD;
      end
      ST_B_PUPD: begin
        gm_we     = 1'b1;
        gm_waddr  = AW'(cm_rd_r.idx);
        state_nxt = ST_IDLE;
      end
      ST_R_EMIT: begin
        if (out_free) begin
          gm_we              = 1'b1;
          gm_wdata           = '0;
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = KIND_GRAD;
          out_value_nxt      = gm_rd_x[VAL_W-1:0];
          out_has_parent_nxt = 1'b0;
          out_chosen_nxt     = '0;
          out_status_nxt     = STAT_OK;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      num_classes_r <= CFG_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      clr_addr_r       <= clr_addr_nxt;
      num_classes_r    <= num_classes_nxt;
      out_valid_r      <= out_valid_nxt;
      cmd_r            <= cmd_nxt;
      ci_r             <= ci_nxt;
      val_r            <= val_nxt;
      cnt_r            <= cnt_nxt;
      slot_r           <= slot_nxt;
      ok_r             <= ok_nxt;
      own_r            <= own_nxt;
      k_r              <= k_nxt;
      n_r              <= n_nxt;
      best_val_r       <= best_val_nxt;
      best_idx_r       <= best_idx_nxt;
      out_kind_r       <= out_kind_nxt;
      out_value_r      <= out_value_nxt;
      out_has_parent_r <= out_has_parent_nxt;
      out_chosen_r     <= out_chosen_nxt;
      out_status_r     <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    if (sm_re) begin
      sm_rd_r <= sm_mem[sm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rd_r <= pm_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cm_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cm_rd_r <= cm_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (gm_we) begin
      gm_mem[gm_waddr] <= gm_wdata;
    end
    if (gm_re) begin
      gm_rd_r <= gm_mem[gm_raddr];
    end
  end

  assign cfg_chan.ready        = 1'b1;
  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_kind_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.has_parent   = out_has_parent_r;
  assign out_chan.chosen_parent = out_chosen_r;
  assign out_chan.status       = out_status_r;

  `HMPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready, "request accepted while the previous one is still in work")
  `HMPA_ASSERT_IMPL(a_parent_only_ok, clk, rst_n, out_valid_r && out_has_parent_r, out_status_r == STAT_OK && out_kind_r == KIND_FORWARD, "chosen parent reported on a failed or non-forward result")
  `HMPA_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_r == ST_F_READ || state_r == ST_F_CMP, k_r < n_r && n_r <= MPC, "parent scan slot beyond the stored count")
  `HMPA_ASSERT_NEXT(a_emit_waits, clk, rst_n, state_r == ST_R_EMIT && out_valid_r && !out_chan.ready, state_r == ST_R_EMIT, "gradient read left its step while the output was still full")

endmodule
